// ----- rtl/ipv4e_pkg.sv -----
// ============================================================================
// ipv4e_pkg
// shared types, constants and register map of the ipv4 header encapsulator
// ============================================================================
package ipv4e_pkg;

    localparam int unsigned HDR_WORDS    = 5;
    localparam int unsigned CNT_W        = $clog2(HDR_WORDS + 1);
    localparam int unsigned ADDR_W       = 5;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned IDX_W        = 3;

    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [15:0] HDR_BYTES    = 16'd20;
    localparam logic [15:0] DF_FLAG      = 16'h4000;
    localparam logic [7:0]  TTL_RESET    = 8'd250;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_ADDR = 3'd0,
        REG_TTL      = 3'd1,
        REG_TOS      = 3'd2,
        REG_PROTO    = 3'd3,
        REG_DF       = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] source_address;
        logic [7:0]  time_to_live;
        logic [7:0]  type_of_service;
        logic [7:0]  protocol_number;
        logic        dont_fragment;
    } t_cfg;

endpackage

// ----- rtl/ipv4e_pkt_if.sv -----
// ============================================================================
// ipv4e_pkt_if
// packet descriptor channel: ip flag, destination address, payload length
// ============================================================================
interface ipv4e_pkt_if;
    logic        valid;
    logic        ready;
    logic        dest_is_ip;
    logic [31:0] dst_addr;
    logic [15:0] payload_length;

    modport source (output valid, output dest_is_ip, output dst_addr,
                    output payload_length, input ready);
    modport sink   (input valid, input dest_is_ip, input dst_addr,
                    input payload_length, output ready);
endinterface

// ----- rtl/ipv4e_hdr_if.sv -----
// ============================================================================
// ipv4e_hdr_if
// header word channel: one 32-bit header word per transfer
// ============================================================================
interface ipv4e_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic        dropped;
    logic        last_word;

    modport source (output valid, output header_word, output dropped,
                    output last_word, input ready);
    modport sink   (input valid, input header_word, input dropped,
                    input last_word, output ready);
endinterface

// ----- rtl/ipv4e_regs.sv -----
// ============================================================================
// ipv4e_regs
// apb configuration registers: source address, ttl, tos, protocol, df
// ============================================================================
module ipv4e_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipv4e_pkg::ADDR_W-1:0] paddr,
    input  logic [ipv4e_pkg::DATA_W-1:0] pwdata,
    output logic [ipv4e_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output ipv4e_pkg::t_cfg              o_cfg
);

    ipv4e_pkg::t_cfg    r_cfg;
    ipv4e_pkg::t_cfg    n_cfg;
    ipv4e_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = ipv4e_pkg::t_reg_idx'(paddr[ipv4e_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                ipv4e_pkg::REG_SRC_ADDR: n_cfg.source_address  = pwdata;
                ipv4e_pkg::REG_TTL:      n_cfg.time_to_live    = pwdata[7:0];
                ipv4e_pkg::REG_TOS:      n_cfg.type_of_service = pwdata[7:0];
                ipv4e_pkg::REG_PROTO:    n_cfg.protocol_number = pwdata[7:0];
                ipv4e_pkg::REG_DF:       n_cfg.dont_fragment   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ipv4e_pkg::REG_SRC_ADDR: prdata = r_cfg.source_address;
            ipv4e_pkg::REG_TTL:      prdata = {24'd0, r_cfg.time_to_live};
            ipv4e_pkg::REG_TOS:      prdata = {24'd0, r_cfg.type_of_service};
            ipv4e_pkg::REG_PROTO:    prdata = {24'd0, r_cfg.protocol_number};
            ipv4e_pkg::REG_DF:       prdata = {31'd0, r_cfg.dont_fragment};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_address  <= '0;
            r_cfg.time_to_live    <= ipv4e_pkg::TTL_RESET;
            r_cfg.type_of_service <= '0;
            r_cfg.protocol_number <= '0;
            r_cfg.dont_fragment   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/ipv4_header_encapsulator_unit.sv -----
// the descriptor is registered in the input stage, then loaded into the header stage
//   once that stage is free; the five header words leave one per cycle on the 32-bit
//   output channel while o_hdr.ready is high; a dropped packet gives a single word
// the next descriptor is taken while the current header is still draining
// reset: synchronous active low; clears the registers to their defaults,
//   the identification counter to zero and empties both stages
// ============================================================================
// ipv4_header_encapsulator_unit
// builds the 20-byte ipv4 header with checksum and streams it as five words
// ============================================================================
module ipv4_header_encapsulator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipv4e_pkg::ADDR_W-1:0] paddr,
    input  logic [ipv4e_pkg::DATA_W-1:0] pwdata,
    output logic [ipv4e_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    ipv4e_pkt_if.sink                    i_pkt,
    ipv4e_hdr_if.source                  o_hdr
);

    ipv4e_pkg::t_cfg w_cfg;

    ipv4e_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input stage
    logic        r_in_vld;
    logic        r_in_ip;
    logic [31:0] r_in_dst;
    logic [15:0] r_in_total;
    logic [17:0] r_in_psum;
    logic [15:0] w_total;

    // header stage
    logic [31:0]     r_hdr [ipv4e_pkg::HDR_WORDS];
    ipv4e_pkg::t_cnt r_left;
    logic            r_drop;
    logic [15:0]     r_ident;

    logic        w_in_take;
    logic        w_out_take;
    logic        w_hdr_free;
    logic        w_load;
    logic [19:0] w_sum;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;
    logic [15:0] w_csum;
    logic [15:0] w_flags;

    assign w_out_take = o_hdr.valid && o_hdr.ready;
    assign w_hdr_free = (r_left == '0) ||
                        ((r_left == ipv4e_pkg::t_cnt'(1)) && w_out_take);
    assign w_load     = r_in_vld && w_hdr_free;
    assign i_pkt.ready = !r_in_vld || w_load;
    assign w_in_take  = i_pkt.valid && i_pkt.ready;
    assign w_total    = i_pkt.payload_length + ipv4e_pkg::HDR_BYTES;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_ip    <= i_pkt.dest_is_ip;
            r_in_dst   <= i_pkt.dst_addr;
            r_in_total <= w_total;
            r_in_psum  <= 18'(i_pkt.dst_addr[31:16]) + 18'(i_pkt.dst_addr[15:0])
                        + 18'(w_total);
        end
    end

    // checksum over the remaining header halves, then end-around fold
    assign w_flags = w_cfg.dont_fragment ? ipv4e_pkg::DF_FLAG : 16'd0;
    assign w_sum   = 20'(r_in_psum)
                   + 20'({ipv4e_pkg::VER_IHL, w_cfg.type_of_service})
                   + 20'(r_ident) + 20'(w_flags)
                   + 20'({w_cfg.time_to_live, w_cfg.protocol_number})
                   + 20'(w_cfg.source_address[31:16])
                   + 20'(w_cfg.source_address[15:0]);
    assign w_fold1 = 17'(w_sum[15:0]) + 17'(w_sum[19:16]);
    assign w_fold2 = 17'(w_fold1[15:0]) + 17'(w_fold1[16]);
    assign w_csum  = ~w_fold2[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_ident <= '0;
        end else if (w_load) begin
            r_left <= r_in_ip ? ipv4e_pkg::t_cnt'(ipv4e_pkg::HDR_WORDS)
                              : ipv4e_pkg::t_cnt'(1);
            if (r_in_ip) begin
                r_ident <= r_ident + 16'd1;
            end
        end else if (w_out_take) begin
            r_left <= r_left - ipv4e_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drop <= !r_in_ip;
            if (r_in_ip) begin
                r_hdr[0] <= {ipv4e_pkg::VER_IHL, w_cfg.type_of_service, r_in_total};
                r_hdr[1] <= {r_ident, w_flags};
                r_hdr[2] <= {w_cfg.time_to_live, w_cfg.protocol_number, w_csum};
                r_hdr[3] <= w_cfg.source_address;
                r_hdr[4] <= r_in_dst;
            end else begin
                r_hdr[0] <= '0;
            end
        end else if (w_out_take) begin
            for (int k = 0; k < ipv4e_pkg::HDR_WORDS - 1; k++) begin
                r_hdr[k] <= r_hdr[k+1];
            end
        end
    end

    assign o_hdr.valid       = (r_left != '0);
    assign o_hdr.header_word = r_hdr[0];
    assign o_hdr.dropped     = r_drop;
    assign o_hdr.last_word   = (r_left == ipv4e_pkg::t_cnt'(1));

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= ipv4e_pkg::t_cnt'(ipv4e_pkg::HDR_WORDS))
        else $error("header word count out of range");

    a_drop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hdr.valid && r_drop) |-> o_hdr.last_word)
        else $error("dropped packet gave more than one word");

    a_ident_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_in_ip) |=> (r_ident == $past(r_ident) + 16'd1))
        else $error("identification did not advance on a header");

    a_ident_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_load && r_in_ip) |=> $stable(r_ident))
        else $error("identification moved without a header");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == '0) |-> i_pkt.ready)
        else $error("input stalled while header stage empty");
`endif

endmodule
